// File: sv/plk_pkg.sv
package plk_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PERIOD_W = 12;
    localparam int COUNT_W = 3;
    localparam int OPCODE_W = 2;
    localparam int VOICE_W = 2;
    localparam int INDEX_W = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int NUM_PERIOD_REGS = 4;

    localparam int DEF_MAX_PERIOD = 2048;
    localparam int DEF_VOICES = 4;

    localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_VOICE_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_FIRST = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_LAST = 3'd4;

    localparam logic [COUNT_W-1:0] VOICE_COUNT_RESET = 3'd1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                   kind;
        logic [VOICE_W-1:0]          voice;
        logic [INDEX_W-1:0]          index;
        logic signed [SAMPLE_W-1:0]  value;
    } t_cmd;

endpackage

// File: sv/plk_front.sv
module plk_front #(
    parameter int MAX_PERIOD = plk_pkg::DEF_MAX_PERIOD,
    parameter int VOICES = plk_pkg::DEF_VOICES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [plk_pkg::OPCODE_W-1:0]         i_opcode,
    input  logic [plk_pkg::VOICE_W-1:0]          i_load_voice,
    input  logic [plk_pkg::INDEX_W-1:0]          i_load_index,
    input  logic signed [plk_pkg::SAMPLE_W-1:0]  i_load_value,
    output logic                                 o_cmd_valid,
    output plk_pkg::t_cmd                        o_cmd,
    input  logic                                 i_cmd_pop
);
    import plk_pkg::*;

    t_cmd       r_queue [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_keep;
    logic       w_push;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd.voice = i_load_voice;
        w_cmd.index = i_load_index;
        w_cmd.value = i_load_value;
        w_cmd.kind = CMD_TICK;
        w_keep = 1'b0;
        case (i_opcode)
            OP_LOAD: begin
                w_cmd.kind = CMD_LOAD;
                w_keep = (32'(i_load_voice) < VOICES) && (32'(i_load_index) < MAX_PERIOD);
            end
            OP_TICK: begin
                w_cmd.kind = CMD_TICK;
                w_keep = 1'b1;
            end
            OP_RESTART: begin
                w_cmd.kind = CMD_RESTART;
                w_keep = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_in_ready = (r_count != 2'd2);
    assign w_push = i_in_valid && o_in_ready && w_keep;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !i_cmd_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!w_push && i_cmd_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// File: sv/plk_div.sv
module plk_div #(
    parameter int SW = 18
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [SW-1:0]                 i_dividend,
    input  logic [plk_pkg::COUNT_W-1:0]          i_divisor,
    output logic                                 o_done,
    output logic signed [plk_pkg::SAMPLE_W-1:0]  o_quotient
);
    import plk_pkg::*;

    localparam int CW = $clog2(SW + 1);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [SW-1:0]      r_quo;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_den;
    logic               r_neg;
    logic [COUNT_W:0]   w_trial;
    logic               w_bit;
    logic [COUNT_W-1:0] w_rem;
    logic [SW-1:0]      w_mag;

    assign w_mag = i_dividend[SW-1] ? $unsigned(-i_dividend) : $unsigned(i_dividend);
    assign w_trial = {r_rem, r_quo[SW-1]};

    always_comb begin
        w_bit = (w_trial >= {1'b0, r_den});
        w_rem = w_bit ? COUNT_W'(w_trial - {1'b0, r_den}) : COUNT_W'(w_trial);
    end

    always_comb begin
        if (r_neg) begin
            if (32'(r_quo) > 32'd32768) begin
                o_quotient = SAMPLE_MIN;
            end else begin
                o_quotient = SAMPLE_W'(-$signed({1'b0, r_quo}));
            end
        end else begin
            if (32'(r_quo) > 32'd32767) begin
                o_quotient = SAMPLE_MAX;
            end else begin
                o_quotient = SAMPLE_W'(r_quo);
            end
        end
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(SW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_den <= (i_divisor == '0) ? COUNT_W'(1) : i_divisor;
            r_neg <= i_dividend[SW-1];
        end else if (r_busy) begin
            r_quo <= {r_quo[SW-2:0], w_bit};
            r_rem <= w_rem;
        end
    end

endmodule

// File: sv/plk_engine.sv
module plk_engine #(
    parameter int MAX_PERIOD = plk_pkg::DEF_MAX_PERIOD,
    parameter int VOICES = plk_pkg::DEF_VOICES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmd_valid,
    input  plk_pkg::t_cmd                        i_cmd,
    output logic                                 o_cmd_pop,
    input  logic [plk_pkg::COUNT_W-1:0]          i_voice_count,
    input  logic [plk_pkg::NUM_PERIOD_REGS-1:0][plk_pkg::PERIOD_W-1:0] i_period,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [plk_pkg::SAMPLE_W-1:0]  o_sample
);
    import plk_pkg::*;

    localparam int PW = $clog2(MAX_PERIOD);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW = VW + PW;
    localparam int SW = SAMPLE_W + $clog2(VOICES);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_VSET = 6'b000010,
        S_CUR  = 6'b000100,
        S_WB   = 6'b001000,
        S_DIV  = 6'b010000,
        S_PUT  = 6'b100000
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    logic [VW-1:0]              r_voice;
    logic [PW-1:0]              r_pos [VOICES];
    logic [PW-1:0]              r_cur_pos;
    logic [PW-1:0]              r_nxt;
    logic signed [SAMPLE_W-1:0] r_cur;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic signed [SW-1:0]       r_sum;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_mem [2**AW];

    logic [PERIOD_W-1:0]        w_per [VOICES];
    logic [PERIOD_W-1:0]        w_cur_per;
    logic                       w_active;
    logic                       w_last;
    logic [PW-1:0]              w_pos_fix;
    logic [PW:0]                w_nxt_sum;
    logic [PW-1:0]              w_nxt;
    logic signed [SAMPLE_W:0]   w_pair;
    logic signed [SAMPLE_W-1:0] w_avg;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic signed [SAMPLE_W-1:0] w_wdata;
    logic [AW-1:0]              w_raddr;
    logic                       w_div_start;
    logic                       w_div_done;
    logic signed [SAMPLE_W-1:0] w_div_q;
    logic                       w_put;

    for (genvar g = 0; g < VOICES; g++) begin : g_per
        if (g < NUM_PERIOD_REGS) begin : g_reg
            assign w_per[g] = (32'(i_period[g]) > MAX_PERIOD) ?
                              PERIOD_W'(MAX_PERIOD) : i_period[g];
        end else begin : g_none
            assign w_per[g] = '0;
        end
    end

    assign w_cur_per = w_per[r_voice];
    assign w_active = (w_cur_per >= PERIOD_W'(2));
    assign w_last = (r_voice == VW'(VOICES - 1));
    assign w_pos_fix = (32'(r_pos[r_voice]) >= 32'(w_cur_per)) ? '0 : r_pos[r_voice];
    assign w_nxt_sum = (PW + 1)'(w_pos_fix) + (PW + 1)'(1);
    assign w_nxt = (32'(w_nxt_sum) >= 32'(w_cur_per)) ? '0 : PW'(w_nxt_sum);
    assign w_pair = (SAMPLE_W + 1)'(r_cur) + (SAMPLE_W + 1)'(r_rd_data);
    assign w_avg = w_pair[SAMPLE_W:1];
    assign w_put = (r_state == S_PUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        o_cmd_pop = 1'b0;
        w_we = 1'b0;
        w_waddr = {r_voice, r_cur_pos};
        w_wdata = w_avg;
        w_raddr = {r_voice, w_pos_fix};
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_LOAD: begin
                            w_we = 1'b1;
                            w_waddr = {VW'(i_cmd.voice), PW'(i_cmd.index)};
                            w_wdata = i_cmd.value;
                        end
                        CMD_TICK: begin
                            n_state = S_VSET;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_VSET: begin
                if (w_active) begin
                    n_state = S_CUR;
                end else if (w_last) begin
                    w_div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_CUR: begin
                w_raddr = {r_voice, r_nxt};
                n_state = S_WB;
            end
            S_WB: begin
                w_we = 1'b1;
                if (w_last) begin
                    w_div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_VSET;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (w_put) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_voice <= '0;
            r_out_valid <= 1'b0;
            for (int v = 0; v < VOICES; v++) begin
                r_pos[v] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_put) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_IDLE && i_cmd_valid) begin
                if (i_cmd.kind == CMD_TICK) begin
                    r_voice <= '0;
                end
                if (i_cmd.kind == CMD_RESTART) begin
                    for (int v = 0; v < VOICES; v++) begin
                        r_pos[v] <= '0;
                    end
                end
            end
            if (r_state == S_VSET && !w_active && !w_last) begin
                r_voice <= r_voice + VW'(1);
            end
            if (r_state == S_WB) begin
                r_pos[r_voice] <= r_nxt;
                if (!w_last) begin
                    r_voice <= r_voice + VW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_sum <= '0;
        end
        if (r_state == S_VSET) begin
            r_cur_pos <= w_pos_fix;
            r_nxt <= w_nxt;
        end
        if (r_state == S_CUR) begin
            r_cur <= r_rd_data;
            r_sum <= r_sum + SW'(r_rd_data);
        end
        if (w_put) begin
            r_sample <= w_div_q;
        end
    end

    plk_div #(
        .SW(SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (i_voice_count),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_sample = r_sample;

endmodule

// File: sv/plucked_string_synth.sv
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_opcode, i_load_voice, i_load_index, i_load_value
// result    o_out_valid / i_out_ready  o_sample
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A two-entry queue takes items at one per cycle while it has room.
// Load and restart are done in the engine's idle state. A tick visits each
// voice in turn, reading and writing back the memory for an active voice,
// then runs the mix divider; its length is set by the delay memory's single
// read port and the one-bit-per-cycle mix divider. Reset is synchronous,
// active low, and leaves all positions at zero. A waiting result stalls the
// engine only when the next tick finishes; configuration writes are always taken.
module plucked_string_synth #(
    parameter int MAX_PERIOD = plk_pkg::DEF_MAX_PERIOD,
    parameter int VOICES = plk_pkg::DEF_VOICES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [plk_pkg::OPCODE_W-1:0]         i_opcode,
    input  logic [plk_pkg::VOICE_W-1:0]          i_load_voice,
    input  logic [plk_pkg::INDEX_W-1:0]          i_load_index,
    input  logic signed [plk_pkg::SAMPLE_W-1:0]  i_load_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [plk_pkg::SAMPLE_W-1:0]  o_sample,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [plk_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [plk_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import plk_pkg::*;

    logic [COUNT_W-1:0]                        r_voice_count;
    logic [NUM_PERIOD_REGS-1:0][PERIOD_W-1:0]  r_period;
    logic                                      w_cmd_valid;
    t_cmd                                      w_cmd;
    logic                                      w_cmd_pop;
    logic [CFG_INDEX_W-1:0]                    w_period_sel;

    assign o_cfg_ready = 1'b1;
    assign w_period_sel = i_cfg_index - CFG_PERIOD_FIRST;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice_count <= VOICE_COUNT_RESET;
            r_period <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_VOICE_COUNT) begin
                r_voice_count <= COUNT_W'(i_cfg_data);
            end else if (i_cfg_index inside {[CFG_PERIOD_FIRST:CFG_PERIOD_LAST]}) begin
                r_period[w_period_sel[1:0]] <= PERIOD_W'(i_cfg_data);
            end
        end
    end

    plk_front #(
        .MAX_PERIOD(MAX_PERIOD),
        .VOICES(VOICES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_load_voice (i_load_voice),
        .i_load_index (i_load_index),
        .i_load_value (i_load_value),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_pop    (w_cmd_pop)
    );

    plk_engine #(
        .MAX_PERIOD(MAX_PERIOD),
        .VOICES(VOICES)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .i_voice_count (r_voice_count),
        .i_period      (r_period),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sample      (o_sample)
    );

endmodule

// File: sv/plk_checker.sv
module plk_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic [plk_pkg::OPCODE_W-1:0]         i_opcode,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [plk_pkg::SAMPLE_W-1:0]  o_sample
);
    import plk_pkg::*;

    logic [2:0] r_pending;
    logic       w_tick_in;
    logic       w_out_take;

    assign w_tick_in = i_in_valid && o_in_ready && (i_opcode == OP_TICK);
    assign w_out_take = o_out_valid && i_out_ready;

    // Ticks accepted whose sample has not been taken yet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_tick_in && !w_out_take) begin
            r_pending <= r_pending + 3'd1;
        end else if (!w_tick_in && w_out_take) begin
            r_pending <= r_pending - 3'd1;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample))
        else $error("stalled result changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 3'd0)
        else $error("result without a tick");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 3'd4 |-> !o_in_ready)
        else $error("input taken with all tick slots full");

endmodule

bind plucked_string_synth plk_checker u_plk_checker (.*);
